>>> hdl/cdcs_pkg.sv
// Shared types and constants for the causal depthwise conv1d + SiLU block.
// Holds field widths, item kind and config index codes, and the sigmoid table.
// No dependencies; every other file in hdl/ uses this package.
package cdcs_pkg;

  localparam int KIND_W     = 3;
  localparam int CH_W       = 6;
  localparam int SLOT_W     = 2;
  localparam int DATA_W     = 16;
  localparam int SEG_IN_W   = 16;
  localparam int ACC_W      = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int SIG_DEPTH  = 256;
  localparam int SIG_IW     = 8;

  // e^-1/16 in Q0.32, step ratio for the sigmoid table build
  localparam logic [31:0] RATIO_Q32 = 32'd4034748382;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 3'd0,
    KIND_TAP    = 3'd1,
    KIND_BIAS   = 3'd2,
    KIND_INIT   = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT   = 1'b0,
    CFG_SILU_ENABLE = 1'b1
  } cfg_idx_e;

  typedef logic [SIG_DEPTH-1:0][15:0] sig_table_t;

  // Sigmoid in Q0.16 sampled at (k-128)/16; evaluated at elaboration only.
  // s(m) = round(2^48 / (2^32 + p(m))) by restoring division.
  function automatic sig_table_t sig_build();
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] rem;
    sig_table_t  t;
    t = '0;
    p = 64'd1 << 32;
    for (int m = 0; m <= 128; m++) begin
      d   = (64'd1 << 32) + p;
      n   = (64'd1 << 48) + (d >> 1);
      rem = '0;
      q   = '0;
      for (int b = 48; b >= 0; b--) begin
        rem = {rem[62:0], n[b]};
        if (rem >= d) begin
          rem  = rem - d;
          q[b] = 1'b1;
        end
      end
      if (m < 128) t[128 + m] = q[15:0];
      if (m > 0) t[128 - m] = 16'(17'h10000 - q[16:0]);
      p = (p * {32'd0, RATIO_Q32} + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = sig_build();

endpackage

>>> hdl/cdcs_in_if.sv
// Input channel of the conv1d block: valid/ready plus one item payload.
// Depends on cdcs_pkg for field widths.
interface cdcs_in_if;
  logic                            valid;
  logic                            ready;
  logic [cdcs_pkg::KIND_W-1:0]     kind;
  logic [cdcs_pkg::CH_W-1:0]       channel;
  logic [cdcs_pkg::SLOT_W-1:0]     slot;
  logic signed [cdcs_pkg::DATA_W-1:0] data_word;
  logic [cdcs_pkg::SEG_IN_W-1:0]   segment;
  logic                            restart;

  modport source (output valid, kind, channel, slot, data_word, segment, restart,
                  input ready);
  modport sink   (input valid, kind, channel, slot, data_word, segment, restart,
                  output ready);
endinterface

>>> hdl/cdcs_out_if.sv
// Result channel of the conv1d block: valid/ready plus one result payload.
// Depends on cdcs_pkg for field widths.
interface cdcs_out_if;
  logic                               valid;
  logic                               ready;
  logic [cdcs_pkg::CH_W-1:0]          out_channel;
  logic signed [cdcs_pkg::DATA_W-1:0] out_value;
  logic                               is_final_state;

  modport source (output valid, out_channel, out_value, is_final_state, input ready);
  modport sink   (input valid, out_channel, out_value, is_final_state, output ready);
endinterface

>>> hdl/causal_depthwise_conv1d_silu.sv
// Per-channel causal FIR of 2 to MAX_TAPS taps with bias and optional SiLU. All
// channel state sits in two single-port-write memories with registered reads:
// a window row (last MAX_TAPS-1 samples with segment tags) and a coefficient
// row (taps, bias, initial state) per channel. One item is in flight at a time.
// For a sample item the taps go one per cycle through a single shared 16x16
// multiplier, followed by a rounding/SiLU stage. Tap, bias and initial-state
// writes read, modify and write back the coefficient row; a final-state query
// reads the window row. Samples and queries also wait on the output register
// while it still holds an untaken result. After reset a clearing pass over
// all CHANNELS rows runs before the first input transfer; configuration
// writes are taken throughout. Depends on cdcs_pkg, cdcs_in_if, cdcs_out_if
// and cdcs_act.
module causal_depthwise_conv1d_silu #(
  parameter int CHANNELS     = 64,
  parameter int MAX_TAPS     = 4,
  parameter int SEGMENT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cdcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cdcs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  cdcs_in_if.sink                           in_i,
  cdcs_out_if.source                        out_o
);

  localparam int WIN    = MAX_TAPS - 1;
  localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_IW = $clog2(MAX_TAPS);
  localparam int WIN_IW = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int ACC_W  = cdcs_pkg::ACC_W;

  typedef struct packed {
    logic                    init;
    logic [SEGMENT_BITS-1:0] seg;
    logic [15:0]             data;
  } win_ent_t;

  typedef win_ent_t [WIN-1:0] win_row_t;

  typedef struct packed {
    logic [MAX_TAPS-1:0][15:0] taps;
    logic [15:0]               bias;
    logic [WIN-1:0][15:0]      init;
  } coef_row_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MAC,
    S_ACC,
    S_ACT,
    S_EMIT
  } state_e;

  // memories
  win_row_t  win_mem  [CHANNELS];
  coef_row_t coef_mem [CHANNELS];
  win_row_t  win_rd_q;
  coef_row_t coef_rd_q;

  // control and item registers
  state_e                   state_q;
  logic [CH_AW-1:0]         clr_q;
  logic [CH_AW-1:0]         ch_q;
  logic [cdcs_pkg::CH_W-1:0] ch_out_q;
  cdcs_pkg::kind_e          kind_q;
  logic [cdcs_pkg::SLOT_W-1:0] slot_q;
  logic [15:0]              data_q;
  logic [SEGMENT_BITS-1:0]  seg_q;
  logic                     rst_q;
  win_row_t                 win_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [31:0]       prod_q;
  logic                     prod_vld_q;
  logic [TAP_IW-1:0]        mac_t_q;
  logic [15:0]              qval_q;
  logic                     act_go_q;
  logic                     out_valid_q;
  logic [cdcs_pkg::CH_W-1:0] out_ch_q;
  logic [15:0]              out_val_q;
  logic                     out_fin_q;

  // configuration
  logic [2:0] tap_cnt_q;
  logic       silu_q;

  // combinational
  logic                    in_fire, item_ok, out_load;
  logic [CH_AW-1:0]        rd_addr;
  logic [2:0]              taps_w, tap_off, q_sum, m_sum;
  win_row_t                reload_row, shift_row, clear_row;
  coef_row_t               coef_mod;
  logic                    win_we, coef_we;
  logic [CH_AW-1:0]        wr_addr;
  logic [15:0]             q_val;
  logic                    mac_last, ent_use;
  win_ent_t                mac_ent;
  logic signed [15:0]      mac_x, mac_w;
  logic signed [31:0]      mac_prod;
  logic                    act_done;
  logic signed [15:0]      act_val;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_cnt_q <= 3'd4;
      silu_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cdcs_pkg::CFG_TAP_COUNT:   tap_cnt_q <= cfg_data_i;
        cdcs_pkg::CFG_SILU_ENABLE: silu_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp kernel width; window offset of the oldest used entry
  always_comb begin
    if (tap_cnt_q < 3'd2) begin
      taps_w = 3'd2;
    end else if (tap_cnt_q > 3'(MAX_TAPS)) begin
      taps_w = 3'(MAX_TAPS);
    end else begin
      taps_w = tap_cnt_q;
    end
    tap_off = 3'(MAX_TAPS) - taps_w;
  end

  // input acceptance
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign item_ok    = (32'(in_i.channel) < 32'(CHANNELS)) &&
                      (in_i.kind <= cdcs_pkg::KIND_QUERY);
  assign rd_addr    = CH_AW'(in_i.channel);

  // restart reload, clear row and shifted window
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      reload_row[j].init = 1'b1;
      reload_row[j].seg  = '0;
      if (3'(j) >= tap_off) begin
        reload_row[j].data = coef_rd_q.init[WIN_IW'(3'(j) - tap_off)];
      end else begin
        reload_row[j].data = '0;
      end
      clear_row[j].init = 1'b1;
      clear_row[j].seg  = '0;
      clear_row[j].data = '0;
    end
    for (int j = 0; j < WIN - 1; j++) begin
      shift_row[j] = win_q[j + 1];
    end
    shift_row[WIN-1].init = 1'b0;
    shift_row[WIN-1].seg  = seg_q;
    shift_row[WIN-1].data = data_q;
  end

  // coefficient row read-modify-write for load kinds
  always_comb begin
    coef_mod = coef_rd_q;
    case (kind_q)
      cdcs_pkg::KIND_TAP: begin
        if (3'(slot_q) < 3'(MAX_TAPS)) coef_mod.taps[TAP_IW'(slot_q)] = data_q;
      end
      cdcs_pkg::KIND_BIAS: coef_mod.bias = data_q;
      cdcs_pkg::KIND_INIT: begin
        if (3'(slot_q) < 3'(WIN)) coef_mod.init[WIN_IW'(slot_q)] = data_q;
      end
      default: ;
    endcase
  end

  // final-state query: raw window entry, zero past the used slots
  always_comb begin
    q_sum = tap_off + 3'(slot_q);
    if (3'(slot_q) < taps_w - 3'd1) begin
      q_val = win_rd_q[WIN_IW'(q_sum)].data;
    end else begin
      q_val = '0;
    end
  end

  // one tap per cycle through the shared multiplier
  always_comb begin
    mac_last = (mac_t_q == TAP_IW'(taps_w - 3'd1));
    m_sum    = tap_off + 3'(mac_t_q);
    mac_ent  = win_q[WIN_IW'(m_sum)];
    ent_use  = mac_ent.init || (mac_ent.seg == seg_q);
    if (mac_last) begin
      mac_x = $signed(data_q);
    end else if (ent_use) begin
      mac_x = $signed(mac_ent.data);
    end else begin
      mac_x = '0;
    end
    mac_w    = $signed(coef_rd_q.taps[mac_t_q]);
    mac_prod = mac_w * mac_x;
  end

  // memory write selection
  assign win_we  = (state_q == S_CLEAR) || (state_q == S_ACC);
  assign coef_we = (state_q == S_CLEAR) ||
                   ((state_q == S_EXEC) && (kind_q == cdcs_pkg::KIND_TAP ||
                                            kind_q == cdcs_pkg::KIND_BIAS ||
                                            kind_q == cdcs_pkg::KIND_INIT));
  assign wr_addr = (state_q == S_CLEAR) ? clr_q : ch_q;

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[wr_addr] <= (state_q == S_CLEAR) ? clear_row : shift_row;
    if (in_fire && item_ok) win_rd_q <= win_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) coef_mem[wr_addr] <= (state_q == S_CLEAR) ? '0 : coef_mod;
    if (in_fire && item_ok) coef_rd_q <= coef_mem[rd_addr];
  end

  // rounding and activation
  cdcs_act u_act (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (act_go_q),
    .acc_i     (acc_q),
    .silu_en_i (silu_q),
    .done_o    (act_done),
    .value_o   (act_val)
  );

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // sequencer, item registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ch_q        <= '0;
      ch_out_q    <= '0;
      kind_q      <= cdcs_pkg::KIND_SAMPLE;
      slot_q      <= '0;
      data_q      <= '0;
      seg_q       <= '0;
      rst_q       <= 1'b0;
      win_q       <= '0;
      acc_q       <= '0;
      prod_q      <= '0;
      prod_vld_q  <= 1'b0;
      mac_t_q     <= '0;
      qval_q      <= '0;
      act_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_ch_q    <= '0;
      out_val_q   <= '0;
      out_fin_q   <= 1'b0;
    end else begin
      // start pulse follows the final accumulate
      act_go_q <= (state_q == S_ACC);
      if (out_valid_q && out_o.ready && !out_load) out_valid_q <= 1'b0;

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CH_AW'(CHANNELS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            ch_q     <= rd_addr;
            ch_out_q <= in_i.channel;
            kind_q   <= cdcs_pkg::kind_e'(in_i.kind);
            slot_q   <= in_i.slot;
            data_q   <= in_i.data_word;
            seg_q    <= SEGMENT_BITS'(in_i.segment);
            rst_q    <= in_i.restart;
            if (item_ok) state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (kind_q)
            cdcs_pkg::KIND_SAMPLE: begin
              win_q      <= rst_q ? reload_row : win_rd_q;
              acc_q      <= ACC_W'($signed(coef_rd_q.bias)) <<< 14;
              mac_t_q    <= '0;
              prod_vld_q <= 1'b0;
              state_q    <= S_MAC;
            end
            cdcs_pkg::KIND_QUERY: begin
              qval_q  <= q_val;
              state_q <= S_EMIT;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_MAC: begin
          prod_q     <= mac_prod;
          prod_vld_q <= 1'b1;
          if (prod_vld_q) acc_q <= acc_q + ACC_W'(prod_q);
          mac_t_q <= mac_t_q + 1'b1;
          if (mac_last) state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q    <= acc_q + ACC_W'(prod_q);
          state_q  <= S_ACT;
        end
        S_ACT: begin
          if (act_done) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_ch_q    <= ch_out_q;
            out_fin_q   <= (kind_q == cdcs_pkg::KIND_QUERY);
            out_val_q   <= (kind_q == cdcs_pkg::KIND_QUERY) ? qval_q : act_val;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_channel    = out_ch_q;
  assign out_o.out_value      = out_val_q;
  assign out_o.is_final_state = out_fin_q;

  // activation result arrives only while the sequencer waits for it
  a_act_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_done |-> (state_q == S_ACT))
    else $error("activation result outside wait state");

  // tap counter never walks past the clamped kernel width
  a_mac_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (3'(mac_t_q) < taps_w))
    else $error("tap counter beyond kernel width");

  // a filtered sample leaves flagged as such
  a_sample_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && kind_q == cdcs_pkg::KIND_SAMPLE) |=>
      (out_o.valid && !out_o.is_final_state))
    else $error("sample result flagged as final state");

endmodule

>>> hdl/cdcs_act.sv
// Output stage: rounds the 40-bit accumulator to Q8.8, applies optional SiLU
// through the sigmoid table, saturates. Three-stage pipeline; uses cdcs_pkg.
module cdcs_act (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [cdcs_pkg::ACC_W-1:0]  acc_i,
  input  logic                               silu_en_i,
  output logic                               done_o,
  output logic signed [cdcs_pkg::DATA_W-1:0] value_o
);

  localparam int VW = cdcs_pkg::ACC_W - 14;  // pre-activation width
  localparam logic signed [cdcs_pkg::ACC_W-1:0] ACC_W_RND = 8192;

  logic                 vld1_q, vld2_q, done_q;
  logic                 sil1_q, sil2_q;
  logic signed [VW-1:0] v1_q, v2_q;
  logic                 hi_q, lo_q;
  logic signed [29:0]   prod_q;
  logic signed [15:0]   val_q;

  logic signed [cdcs_pkg::ACC_W-1:0] acc_rnd;
  logic signed [VW-1:0]              v_ofs;
  logic [cdcs_pkg::SIG_IW-1:0]       sig_idx;
  logic [15:0]                       sig_val;
  logic signed [29:0]                prod_rnd;
  logic signed [VW-1:0]              act_v;
  logic signed [15:0]                sat_v;

  // stage 1: round half up, floor shift by 14
  assign acc_rnd = acc_i + ACC_W_RND;

  // stage 2: table lookup and v * sigmoid
  assign v_ofs   = v1_q + VW'(2048);
  assign sig_idx = v_ofs[11:4];
  assign sig_val = cdcs_pkg::SIG_TABLE[sig_idx];

  // stage 3: select, round product, saturate
  assign prod_rnd = prod_q + 30'sd32768;

  always_comb begin
    if (!sil2_q || hi_q) begin
      act_v = v2_q;
    end else if (lo_q) begin
      act_v = '0;
    end else begin
      act_v = VW'($signed(prod_rnd[29:16]));
    end
    if (act_v > VW'(32767)) begin
      sat_v = 16'sh7FFF;
    end else if (act_v < -VW'(32768)) begin
      sat_v = -16'sh8000;
    end else begin
      sat_v = act_v[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
      vld2_q <= vld1_q;
      done_q <= vld2_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    v1_q   <= acc_rnd[cdcs_pkg::ACC_W-1:14];
    sil1_q <= silu_en_i;
    v2_q   <= v1_q;
    sil2_q <= sil1_q;
    hi_q   <= (v1_q >= VW'(2048));
    lo_q   <= (v1_q < -VW'(2048));
    prod_q <= 30'($signed(v1_q[12:0]) * $signed({1'b0, sig_val}));
    if (vld2_q) val_q <= sat_v;
  end

  assign done_o  = done_q;
  assign value_o = val_q;

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for causal_depthwise_conv1d_silu: directed table, then
// random phases over tap count / SiLU settings, scored by an in-bench predictor.
// Depends on cdcs_pkg, cdcs_in_if, cdcs_out_if and the block under test.
module tb;

  localparam int N_CH         = 64;
  localparam int N_TAPS       = 4;
  localparam int WIN_LEN      = N_TAPS - 1;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_LIMIT = 4000;
  localparam int TAIL_CYCLES  = 32;
  localparam int N_PHASES     = 11;
  localparam int PHASE_ITEMS  = 112;
  localparam logic [cdcs_pkg::KIND_W-1:0] KIND_LAST = 3'd7;
  localparam logic [16:0] TAG_INIT = 17'h10000;
  localparam longint unsigned E_STEP_Q32 = 64'd4034748382;

  typedef struct {
    logic [cdcs_pkg::KIND_W-1:0]        kind;
    logic [cdcs_pkg::CH_W-1:0]          ch;
    logic [cdcs_pkg::SLOT_W-1:0]        slot;
    logic signed [cdcs_pkg::DATA_W-1:0] data;
    logic [cdcs_pkg::SEG_IN_W-1:0]      seg;
    logic                               restart;
  } conv_item_t;

  typedef struct {
    logic [cdcs_pkg::CH_W-1:0]          ch;
    logic signed [cdcs_pkg::DATA_W-1:0] value;
    logic                               final_st;
  } conv_res_t;

  typedef struct {
    conv_item_t                         it;
    bit                                 typed;
    logic signed [cdcs_pkg::DATA_W-1:0] tval;
  } dir_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [cdcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [cdcs_pkg::CFG_DATA_W-1:0] cfg_data_i;

  cdcs_in_if  in_if ();
  cdcs_out_if out_if ();

  causal_depthwise_conv1d_silu dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predictor state: per-channel window, taps, bias, initial state, settings
  logic signed [15:0] win_data [N_CH][WIN_LEN];
  logic [16:0]        win_tag  [N_CH][WIN_LEN];
  logic signed [15:0] tap_w    [N_CH][N_TAPS];
  logic signed [15:0] bias_q   [N_CH];
  logic signed [15:0] init_q   [N_CH][WIN_LEN];
  logic [2:0]         cfg_taps;
  logic               cfg_silu;
  int                 sig_lut  [256];

  conv_res_t          expected_q [$];
  logic [1:0]         idle_mode;   // bit 0: source gaps, bit 1: sink stalls
  logic [cdcs_pkg::CH_W-1:0] act_ch [3];
  logic [15:0]        seg_cur [N_CH];
  int                 n_items;
  int                 n_results;
  int                 n_errors;
  dir_row_t           dir_rows [23];
  int                 ph_taps [N_PHASES];
  int                 ph_silu [N_PHASES];
  int                 ph_mode [N_PHASES];

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sigmoid in Q0.16 at (k-128)/16, built from a geometric series of e^-1/16
  function automatic void build_sig_lut();
    longint unsigned p;
    longint unsigned d;
    longint unsigned s;
    p = 64'd1 << 32;
    for (int m = 0; m <= 128; m++) begin
      d = (64'd1 << 32) + p;
      s = ((64'd1 << 48) + d / 2) / d;
      if (m < 128) sig_lut[128 + m] = int'(s);
      if (m > 0) sig_lut[128 - m] = 65536 - int'(s);
      p = (p * E_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic void conv_state_reset();
    for (int c = 0; c < N_CH; c++) begin
      bias_q[c]  = '0;
      seg_cur[c] = '0;
      for (int j = 0; j < WIN_LEN; j++) begin
        win_data[c][j] = '0;
        win_tag[c][j]  = TAG_INIT;
        init_q[c][j]   = '0;
      end
      for (int t = 0; t < N_TAPS; t++) tap_w[c][t] = '0;
    end
    cfg_taps = 3'd4;
    cfg_silu = 1'b0;
  endfunction

  // Expected result of one item; returns 1 when the item yields a result
  function automatic bit conv_predict(input conv_item_t it, output conv_res_t r);
    int     w;
    int     j;
    longint acc;
    longint v;
    w = (cfg_taps < 2) ? 2 : ((cfg_taps > N_TAPS) ? N_TAPS : int'(cfg_taps));
    r.ch       = it.ch;
    r.value    = '0;
    r.final_st = 1'b0;
    case (it.kind)
      cdcs_pkg::KIND_TAP: begin
        tap_w[it.ch][it.slot] = it.data;
        return 1'b0;
      end
      cdcs_pkg::KIND_BIAS: begin
        bias_q[it.ch] = it.data;
        return 1'b0;
      end
      cdcs_pkg::KIND_INIT: begin
        if (it.slot < WIN_LEN) init_q[it.ch][it.slot] = it.data;
        return 1'b0;
      end
      cdcs_pkg::KIND_QUERY: begin
        if (it.slot < w - 1) r.value = win_data[it.ch][N_TAPS - w + it.slot];
        r.final_st = 1'b1;
        return 1'b1;
      end
      cdcs_pkg::KIND_SAMPLE: begin
        // restart: reload the window from initial state, all marked initial
        if (it.restart) begin
          for (int k = 1; k <= WIN_LEN; k++) begin
            j = WIN_LEN - k;
            win_data[it.ch][j] = (k <= w - 1) ? init_q[it.ch][w - 1 - k] : 16'sd0;
            win_tag[it.ch][j]  = TAG_INIT;
          end
        end
        acc = longint'(bias_q[it.ch]) * 16384;
        for (int i = 0; i < w - 1; i++) begin
          j = N_TAPS - w + i;
          // earlier samples count only within the same segment
          if (win_tag[it.ch][j][16] || win_tag[it.ch][j][15:0] == it.seg)
            acc += longint'(tap_w[it.ch][i]) * longint'(win_data[it.ch][j]);
        end
        acc += longint'(tap_w[it.ch][w - 1]) * longint'(it.data);
        v = (acc + 8192) >>> 14;
        if (cfg_silu) begin
          if (v < -2048) v = 0;
          else if (v < 2048) v = (v * longint'(sig_lut[(v + 2048) >>> 4]) + 32768) >>> 16;
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        for (int k = 0; k < WIN_LEN - 1; k++) begin
          win_data[it.ch][k] = win_data[it.ch][k + 1];
          win_tag[it.ch][k]  = win_tag[it.ch][k + 1];
        end
        win_data[it.ch][WIN_LEN - 1] = it.data;
        win_tag[it.ch][WIN_LEN - 1]  = {1'b0, it.seg};
        r.value = v[15:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic conv_item_t mk_item(input logic [cdcs_pkg::KIND_W-1:0] kind,
                                         input logic [cdcs_pkg::CH_W-1:0] ch,
                                         input logic [cdcs_pkg::SLOT_W-1:0] slot,
                                         input logic signed [cdcs_pkg::DATA_W-1:0] data);
    conv_item_t it;
    it.kind    = kind;
    it.ch      = ch;
    it.slot    = slot;
    it.data    = data;
    it.seg     = 16'($urandom);
    it.restart = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Q8.8 values: mostly small so SiLU's curved range is hit, some full range
  function automatic logic signed [15:0] rand_q88();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2047) - 1024);
  endfunction

  // Q2.14 weights: mostly within +-1.0
  function automatic logic signed [15:0] rand_weight();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 32767) - 16384);
  endfunction

  function automatic logic [15:0] new_segment();
    if ($urandom_range(0, 1) == 1) return 16'($urandom);
    return 16'($urandom_range(0, 3));
  endfunction

  function automatic conv_item_t rand_item();
    conv_item_t it;
    int         r;
    it = mk_item(cdcs_pkg::KIND_SAMPLE, '0, 2'($urandom_range(0, 3)), '0);
    it.ch = ($urandom_range(0, 99) < 85) ? act_ch[$urandom_range(0, 2)]
                                         : 6'($urandom_range(0, N_CH - 1));
    r = $urandom_range(0, 99);
    if (r < 6) begin
      it.kind = cdcs_pkg::KIND_TAP;
      it.data = rand_weight();
    end else if (r < 9) begin
      it.kind = cdcs_pkg::KIND_BIAS;
      it.data = rand_q88();
    end else if (r < 13) begin
      it.kind = cdcs_pkg::KIND_INIT;
      it.data = rand_q88();
    end else if (r < 20) begin
      it.kind = cdcs_pkg::KIND_QUERY;
      it.data = 16'($urandom);
    end else if (r < 23) begin
      it.kind = 3'($urandom_range(int'(cdcs_pkg::KIND_QUERY) + 1,
                                  int'(KIND_LAST)));
      it.data = 16'($urandom);
    end else begin
      // sample rows: restart opens a new segment, sometimes a segment
      // changes without a restart, and a few carry a stray segment
      it.kind    = cdcs_pkg::KIND_SAMPLE;
      it.data    = rand_q88();
      it.restart = ($urandom_range(0, 99) < 12);
      if (it.restart || $urandom_range(0, 99) < 10) seg_cur[it.ch] = new_segment();
      it.seg = ($urandom_range(0, 99) < 5) ? new_segment() : seg_cur[it.ch];
    end
    return it;
  endfunction

  // One input transfer; the predictor runs when the block takes the item
  task automatic apply_item(input conv_item_t it, input bit typed,
                            input logic signed [cdcs_pkg::DATA_W-1:0] tval);
    int        gap;
    conv_res_t r;
    bit        has;
    gap = idle_mode[0] ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= it.kind;
    in_if.channel   <= it.ch;
    in_if.slot      <= it.slot;
    in_if.data_word <= it.data;
    in_if.segment   <= it.seg;
    in_if.restart   <= it.restart;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    has = conv_predict(it, r);
    if (has) begin
      if (typed) r.value = tval;
      expected_q.push_back(r);
    end
    if (it.kind <= cdcs_pkg::KIND_QUERY) n_items++;
  endtask

  // Wait for outstanding results, then let any item without a result finish
  task automatic settle();
    int k;
    k = 0;
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0 && k < SETTLE_LIMIT) begin
      @(posedge clk_i);
      k++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Both registers written back to back, write enable held across
  task automatic cfg_set(input int taps,
                         input logic [cdcs_pkg::CFG_DATA_W-1:0] silu_data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= cdcs_pkg::CFG_TAP_COUNT;
    cfg_data_i <= 3'(taps);
    @(posedge clk_i);
    cfg_idx_i  <= cdcs_pkg::CFG_SILU_ENABLE;
    cfg_data_i <= silu_data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_taps = 3'(taps);
    cfg_silu = silu_data[0];
  endtask

  task automatic run_phase(input int taps, input int silu, input int mode);
    int start;
    idle_mode = 2'(mode);
    cfg_set(taps, {2'($urandom_range(0, 3)), 1'(silu)});
    for (int a = 0; a < 3; a++) act_ch[a] = 6'($urandom_range(0, N_CH - 1));
    // load coefficients and initial state of the busy channels first
    for (int a = 0; a < 3; a++) begin
      for (int t = 0; t < N_TAPS; t++)
        apply_item(mk_item(cdcs_pkg::KIND_TAP, act_ch[a], 2'(t), rand_weight()),
                   1'b0, '0);
      apply_item(mk_item(cdcs_pkg::KIND_BIAS, act_ch[a], '0, rand_q88()), 1'b0, '0);
      for (int t = 0; t < WIN_LEN; t++)
        apply_item(mk_item(cdcs_pkg::KIND_INIT, act_ch[a], 2'(t), rand_q88()),
                   1'b0, '0);
    end
    start = n_items;
    while (n_items - start < PHASE_ITEMS) apply_item(rand_item(), 1'b0, '0);
    settle();
  endtask

  // Result side: random stalls, each transfer checked against the oldest expectation
  task automatic check_result();
    conv_res_t e;
    n_results++;
    if (expected_q.size() == 0) begin
      $error("unexpected result: channel %0d value %0d", out_if.out_channel,
             out_if.out_value);
      n_errors++;
    end else begin
      e = expected_q.pop_front();
      if (out_if.out_channel !== e.ch) begin
        $error("out_channel: expected %0d, got %0d", e.ch, out_if.out_channel);
        n_errors++;
      end
      if (out_if.out_value !== e.value) begin
        $error("out_value: expected %0d, got %0d", e.value, out_if.out_value);
        n_errors++;
      end
      if (out_if.is_final_state !== e.final_st) begin
        $error("is_final_state: expected %0d, got %0d", e.final_st,
               out_if.is_final_state);
        n_errors++;
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_mode[1] ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      check_result();
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = cdcs_pkg::CFG_TAP_COUNT;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.kind      = cdcs_pkg::KIND_SAMPLE;
    in_if.channel   = '0;
    in_if.slot      = '0;
    in_if.data_word = '0;
    in_if.segment   = '0;
    in_if.restart   = 1'b0;
    idle_mode       = 2'b11;
    n_items         = 0;
    n_results       = 0;
    n_errors        = 0;
    build_sig_lut();
    conv_state_reset();

    // kind, channel, slot, data, segment, restart; typed flag and value
    dir_rows = '{
      '{'{cdcs_pkg::KIND_QUERY,  6'd0,  2'd0, 16'sd0,     16'h0000, 1'b0}, 1'b1, 16'sd0},
      '{'{cdcs_pkg::KIND_QUERY,  6'd63, 2'd3, 16'sd0,     16'h0000, 1'b0}, 1'b1, 16'sd0},
      '{'{cdcs_pkg::KIND_SAMPLE, 6'd63, 2'd0, 16'sh7FFF,  16'hFFFF, 1'b1}, 1'b1, 16'sd0},
      '{'{cdcs_pkg::KIND_TAP,    6'd1,  2'd3, 16'sd16384, 16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_TAP,    6'd1,  2'd0, 16'sh8000,  16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_BIAS,   6'd1,  2'd0, 16'sd256,   16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_SAMPLE, 6'd1,  2'd0, 16'sh7FFF,  16'h0000, 1'b1}, 1'b1,
        16'sh7FFF},
      '{'{cdcs_pkg::KIND_SAMPLE, 6'd1,  2'd0, 16'sh8000,  16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_SAMPLE, 6'd1,  2'd0, 16'sd100,   16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_SAMPLE, 6'd1,  2'd0, 16'sd100,   16'h0001, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_INIT,   6'd2,  2'd0, 16'sh7FFF,  16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_INIT,   6'd2,  2'd2, 16'sh8000,  16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_INIT,   6'd2,  2'd3, 16'sd123,   16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_TAP,    6'd2,  2'd0, 16'sd16384, 16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_TAP,    6'd2,  2'd2, 16'sh8000,  16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_SAMPLE, 6'd2,  2'd0, 16'sd0,     16'hFFFF, 1'b1}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_QUERY,  6'd2,  2'd0, 16'sd0,     16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_QUERY,  6'd2,  2'd2, 16'sd0,     16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{KIND_LAST,             6'd3,  2'd0, 16'sd7,     16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_TAP,    6'd4,  2'd3, 16'sh8000,  16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_BIAS,   6'd4,  2'd0, 16'sh8000,  16'h0000, 1'b0}, 1'b0, 16'sd0},
      '{'{cdcs_pkg::KIND_SAMPLE, 6'd4,  2'd0, 16'sh7FFF,  16'h0000, 1'b1}, 1'b1,
        16'sh8000},
      '{'{cdcs_pkg::KIND_SAMPLE, 6'd1,  2'd0, 16'sh8000,  16'h0001, 1'b0}, 1'b0, 16'sd0}
    };
    // settings per random phase; 0, 1, 5..7 exercise the tap-count clamp
    ph_taps = '{2, 3, 4, 0, 7, 5, 1, 3, 4, 6, 2};
    ph_silu = '{0, 1, 1, 0, 1, 0, 1, 0, 1, 0, 1};
    ph_mode = '{3, 3, 1, 3, 0, 2, 3, 3, 1, 3, 3};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset settings, written explicitly
    cfg_set(4, 3'd0);
    foreach (dir_rows[i]) apply_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].tval);
    settle();

    for (int p = 0; p < N_PHASES; p++) run_phase(ph_taps[p], ph_silu[p], ph_mode[p]);

    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      n_errors++;
    end
    $display("covered %0d items over %0d tap-count/SiLU settings, %0d results checked",
             n_items, N_PHASES + 1, n_results);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
